/* src/lrpd_pkg.sv */
// Shared constants, field widths and the checksum fold for the range packet decoder.
// No dependencies; compiled first.
package lrpd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ANGLE_W  = 9;
   localparam int unsigned DIST_W   = 14;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned SLOT_W   = 2;
   localparam int unsigned READINGS = 4;
   // ten words weighted by 2^9 down to 2^0 stay below 2^26
   localparam int unsigned ACC_W    = 26;
   localparam int unsigned CHK_W    = 15;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFA;
   localparam logic [BYTE_W-1:0] INDEX_LO  = 8'hA0;
   localparam logic [BYTE_W-1:0] INDEX_HI  = 8'hF9;

   localparam logic [POS_W-1:0] POS_SYNC      = 5'd0;
   localparam logic [POS_W-1:0] POS_INDEX     = 5'd1;
   localparam logic [POS_W-1:0] POS_PAYLOAD   = 5'd2;
   localparam logic [POS_W-1:0] POS_SPEED_HI  = 5'd3;
   localparam logic [POS_W-1:0] POS_READ_HI   = 5'd5;
   localparam logic [POS_W-1:0] POS_CHK_LAST  = 5'd19;
   localparam logic [POS_W-1:0] POS_LAST      = 5'd21;

   localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

   // end-around fold of the shift-and-add accumulator to 15 bits
   function automatic logic [CHK_W-1:0] fold_checksum(input logic [ACC_W-1:0] acc);
      logic [CHK_W:0] sum;
      sum = {1'b0, acc[CHK_W-1:0]} + {{(2*CHK_W+1-ACC_W){1'b0}}, acc[ACC_W-1:CHK_W]};
      return sum[CHK_W-1:0];
   endfunction

endpackage

/* src/lrpd_req_if.sv */
// Byte input channel: valid/ready handshake carrying one received serial byte.
// Depends on lrpd_pkg.
interface lrpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [lrpd_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/lrpd_rsp_if.sv */
// Reading output channel: valid/ready handshake carrying one decoded range reading.
// Depends on lrpd_pkg.
interface lrpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lrpd_pkg::ANGLE_W-1:0]  angle_deg;
   logic [lrpd_pkg::DIST_W-1:0]   distance_mm;
   logic [lrpd_pkg::WORD_W-1:0]   signal_strength;
   logic [lrpd_pkg::WORD_W-1:0]   speed_raw;
   logic                          last_of_packet;

   modport source (output valid, output angle_deg, output distance_mm,
                   output signal_strength, output speed_raw, output last_of_packet,
                   input ready);
   modport sink   (input valid, input angle_deg, input distance_mm,
                   input signal_strength, input speed_raw, input last_of_packet,
                   output ready);
endinterface

/* src/lidar_range_packet_decoder.sv */
// Range packet decoder top level: byte framing, running checksum and reading drain.
// Depends on lrpd_pkg, lrpd_req_if, lrpd_rsp_if.
//
//   channel  | dir | word                      | handshake
//   ---------+-----+---------------------------+----------------
//   req_ch   | in  | rx_byte (8b)              | valid & ready
//   rsp_ch   | out | angle, distance, strength,| valid & ready
//            |     | speed, last_of_packet     |
//
// One byte per cycle: a byte is taken in the cycle it is offered unless the stall
// below applies; framing, field capture and the shift-and-add checksum all update
// in that single cycle.
// A good 22-byte packet is copied into an output bank when its last byte is taken;
// the first word shows the next cycle and the four words drain one per cycle while
// rsp_ch.ready is high, as the next packet's bytes keep arriving.
// req_ch.ready drops only while framing waits for the final byte of a packet and
// the output bank still holds undrained words; it rises the cycle after the bank's
// last word is taken.
// Reset (synchronous, active high) returns framing to sync search and empties
// the output bank.
module lidar_range_packet_decoder (
   input  logic             clock,
   input  logic             reset,
   lrpd_req_if.sink         req_ch,
   lrpd_rsp_if.source       rsp_ch
);

   // framing and checksum
   logic [lrpd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [lrpd_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [lrpd_pkg::BYTE_W-1:0]  lo_ff, lo_in;      // low byte of the word in flight

   // fields of the packet being received
   logic [lrpd_pkg::BYTE_W-1:0]  index_ff, index_in;
   logic [lrpd_pkg::WORD_W-1:0]  speed_ff, speed_in;
   logic [lrpd_pkg::DIST_W-1:0]  dist_ff  [lrpd_pkg::READINGS];
   logic [lrpd_pkg::DIST_W-1:0]  dist_in  [lrpd_pkg::READINGS];
   logic [lrpd_pkg::WORD_W-1:0]  inten_ff [lrpd_pkg::READINGS];
   logic [lrpd_pkg::WORD_W-1:0]  inten_in [lrpd_pkg::READINGS];

   // output bank of the last good packet
   logic                         pend_ff, pend_in;
   logic [lrpd_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [lrpd_pkg::BYTE_W-1:0]  oindex_ff, oindex_in;
   logic [lrpd_pkg::WORD_W-1:0]  ospeed_ff, ospeed_in;
   logic [lrpd_pkg::DIST_W-1:0]  odist_ff  [lrpd_pkg::READINGS];
   logic [lrpd_pkg::DIST_W-1:0]  odist_in  [lrpd_pkg::READINGS];
   logic [lrpd_pkg::WORD_W-1:0]  ointen_ff [lrpd_pkg::READINGS];
   logic [lrpd_pkg::WORD_W-1:0]  ointen_in [lrpd_pkg::READINGS];

   logic                          req_take;
   logic                          rsp_take;
   logic [lrpd_pkg::BYTE_W-1:0]   c;
   logic [lrpd_pkg::WORD_W-1:0]   word;
   logic [lrpd_pkg::SLOT_W-1:0]   rd_slot;
   logic                          chk_good;
   logic [lrpd_pkg::BYTE_W-1:0]   angle_base;

   assign c        = req_ch.rx_byte;
   assign word     = {c, lo_ff};
   // readings start at byte 4; odd position p belongs to slot p[4:2]-1
   assign rd_slot  = lrpd_pkg::SLOT_W'(pos_ff[4:2] - 3'd1);
   assign chk_good = (word == {1'b0, lrpd_pkg::fold_checksum(acc_ff)});

   // last byte waits until the bank has drained
   assign req_ch.ready = !((pos_ff == lrpd_pkg::POS_LAST) && pend_ff);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      lo_in     = lo_ff;
      index_in  = index_ff;
      speed_in  = speed_ff;
      dist_in   = dist_ff;
      inten_in  = inten_ff;
      pend_in   = pend_ff;
      slot_in   = slot_ff;
      oindex_in = oindex_ff;
      ospeed_in = ospeed_ff;
      odist_in  = odist_ff;
      ointen_in = ointen_ff;

      if (rsp_take) begin
         slot_in = slot_ff + 2'd1;
         if (slot_ff == lrpd_pkg::SLOT_LAST) begin
            pend_in = 1'b0;
         end
      end

      if (req_take) begin
         case (pos_ff)
            lrpd_pkg::POS_SYNC: begin
               pos_in = (c == lrpd_pkg::SYNC_BYTE) ? lrpd_pkg::POS_INDEX : lrpd_pkg::POS_SYNC;
            end
            lrpd_pkg::POS_INDEX: begin
               if ((c >= lrpd_pkg::INDEX_LO) && (c <= lrpd_pkg::INDEX_HI)) begin
                  pos_in   = lrpd_pkg::POS_PAYLOAD;
                  index_in = c;
                  // first word is always {index, sync}
                  acc_in   = {{(lrpd_pkg::ACC_W-lrpd_pkg::WORD_W){1'b0}}, c, lrpd_pkg::SYNC_BYTE};
               end else if (c != lrpd_pkg::SYNC_BYTE) begin
                  pos_in = lrpd_pkg::POS_SYNC;
               end
            end
            default: begin
               lo_in = c;
               if (pos_ff == lrpd_pkg::POS_LAST) begin
                  pos_in = lrpd_pkg::POS_SYNC;
                  if (chk_good) begin
                     pend_in   = 1'b1;
                     slot_in   = '0;
                     oindex_in = index_ff;
                     ospeed_in = speed_ff;
                     odist_in  = dist_ff;
                     ointen_in = inten_ff;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
                  if (pos_ff[0] && (pos_ff <= lrpd_pkg::POS_CHK_LAST)) begin
                     acc_in = {acc_ff[lrpd_pkg::ACC_W-2:0], 1'b0}
                            + {{(lrpd_pkg::ACC_W-lrpd_pkg::WORD_W){1'b0}}, word};
                     if (pos_ff == lrpd_pkg::POS_SPEED_HI) begin
                        speed_in = word;
                     end else if (pos_ff >= lrpd_pkg::POS_READ_HI) begin
                        if (pos_ff[1]) begin
                           inten_in[rd_slot] = word;
                        end else begin
                           dist_in[rd_slot] = word[lrpd_pkg::DIST_W-1:0];
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= lrpd_pkg::POS_SYNC;
         pend_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         slot_ff <= slot_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      lo_ff     <= lo_in;
      index_ff  <= index_in;
      speed_ff  <= speed_in;
      dist_ff   <= dist_in;
      inten_ff  <= inten_in;
      oindex_ff <= oindex_in;
      ospeed_ff <= ospeed_in;
      odist_ff  <= odist_in;
      ointen_ff <= ointen_in;
   end

   // angle = (index - 0xA0) * 4 + slot; index - 0xA0 fits in 7 bits
   assign angle_base = oindex_ff - lrpd_pkg::INDEX_LO;

   assign rsp_ch.valid           = pend_ff;
   assign rsp_ch.angle_deg       = {angle_base[lrpd_pkg::ANGLE_W-lrpd_pkg::SLOT_W-1:0], slot_ff};
   assign rsp_ch.distance_mm     = odist_ff[slot_ff];
   assign rsp_ch.signal_strength = ointen_ff[slot_ff];
   assign rsp_ch.speed_raw       = ospeed_ff;
   assign rsp_ch.last_of_packet  = (slot_ff == lrpd_pkg::SLOT_LAST);

endmodule

/* src/lrpd_checker.sv */
// Port-level checks for the range packet decoder, bound onto the top level.
// Depends on lrpd_pkg and lidar_range_packet_decoder.
module lrpd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lrpd_pkg::ANGLE_W-1:0]  rsp_angle_deg,
   input logic [lrpd_pkg::WORD_W-1:0]   rsp_speed_raw,
   input logic                          rsp_last_of_packet
);

   logic rsp_take;
   assign rsp_take = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle_deg))
      else $error("rsp word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // within a packet words come back to back with rising angle and same speed
   a_packet_run: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_of_packet |=>
         rsp_valid && (rsp_angle_deg == $past(rsp_angle_deg) + 9'd1)
         && (rsp_speed_raw == $past(rsp_speed_raw)))
      else $error("packet words not contiguous");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_packet == (rsp_angle_deg[1:0] == lrpd_pkg::SLOT_LAST)))
      else $error("last_of_packet does not match slot");

endmodule

bind lidar_range_packet_decoder lrpd_checker u_lrpd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_angle_deg      (rsp_ch.angle_deg),
   .rsp_speed_raw      (rsp_ch.speed_raw),
   .rsp_last_of_packet (rsp_ch.last_of_packet)
);

/* sim/lrpd_checker.sv */
// Scoreboard for the range packet decoder: tracks packet framing from the byte
// channel, predicts the readings of each good packet and checks the reading channel.
// Depends on lrpd_pkg.
module lrpd_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [lrpd_pkg::BYTE_W-1:0]   req_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [lrpd_pkg::ANGLE_W-1:0]  rsp_angle,
   input  logic [lrpd_pkg::DIST_W-1:0]   rsp_distance,
   input  logic [lrpd_pkg::WORD_W-1:0]   rsp_strength,
   input  logic [lrpd_pkg::WORD_W-1:0]   rsp_speed,
   input  logic                          rsp_last,
   output int                            mismatches,
   output int                            readings_pending,
   output int                            readings_checked,
   output int                            packets_good,
   output int                            packets_dropped
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES   = 22;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct packed {
      logic [lrpd_pkg::ANGLE_W-1:0] angle;
      logic [lrpd_pkg::DIST_W-1:0]  distance;
      logic [lrpd_pkg::WORD_W-1:0]  strength;
      logic [lrpd_pkg::WORD_W-1:0]  speed;
      logic                         last;
   } reading_type;

   reading_type                 expected_readings [$];
   logic [lrpd_pkg::POS_W-1:0]  frame_pos;
   logic [lrpd_pkg::BYTE_W-1:0] frame_buf [FRAME_BYTES];

   function automatic logic [lrpd_pkg::WORD_W-1:0] le_word(input int at);
      return {frame_buf[at+1], frame_buf[at]};
   endfunction

   // one byte into the framing model; a good packet queues four readings
   task automatic decode_byte(input logic [lrpd_pkg::BYTE_W-1:0] b);
      logic [lrpd_pkg::POS_W-1:0] p;
      logic [31:0]                acc;
      logic [31:0]                folded;
      reading_type                r;
      int                         w;
      int                         s;
      p = (frame_pos > lrpd_pkg::POS_LAST) ? lrpd_pkg::POS_SYNC : frame_pos;
      frame_buf[p] = b;
      if (p == lrpd_pkg::POS_SYNC) begin
         frame_pos = (b == lrpd_pkg::SYNC_BYTE) ? lrpd_pkg::POS_INDEX : lrpd_pkg::POS_SYNC;
      end else if (p == lrpd_pkg::POS_INDEX) begin
         if (b >= lrpd_pkg::INDEX_LO && b <= lrpd_pkg::INDEX_HI) begin
            frame_pos = lrpd_pkg::POS_PAYLOAD;
         end else if (b != lrpd_pkg::SYNC_BYTE) begin
            frame_pos = lrpd_pkg::POS_SYNC;
         end
      end else if (p != lrpd_pkg::POS_LAST) begin
         frame_pos = p + 1'b1;
      end else begin
         frame_pos = lrpd_pkg::POS_SYNC;
         acc = '0;
         for (w = 0; w < 10; w++) begin
            acc = (acc << 1) + le_word(2 * w);
         end
         folded = ((acc & 32'h7FFF) + (acc >> 15)) & 32'h7FFF;
         if (le_word(20) != folded[lrpd_pkg::WORD_W-1:0]) begin
            packets_dropped++;
         end else begin
            packets_good++;
            for (s = 0; s < lrpd_pkg::READINGS; s++) begin
               r.angle    = lrpd_pkg::ANGLE_W'((int'(frame_buf[1])
                                                - int'(lrpd_pkg::INDEX_LO)) * 4 + s);
               r.distance = lrpd_pkg::DIST_W'(le_word(4 + 4 * s));
               r.strength = le_word(6 + 4 * s);
               r.speed    = le_word(2);
               r.last     = (s == lrpd_pkg::READINGS - 1);
               expected_readings.push_back(r);
            end
         end
      end
   endtask

   task automatic check_reading();
      reading_type got;
      reading_type want;
      got = {rsp_angle, rsp_distance, rsp_strength, rsp_speed, rsp_last};
      if (expected_readings.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOWN_ERRORS) begin
            $display("unexpected reading at %0t: angle %0d dist %0d strength %0d",
                     $time, got.angle, got.distance, got.strength);
            $display("   speed %0d last %0b", got.speed, got.last);
         end
      end else begin
         want = expected_readings.pop_front();
         readings_checked++;
         if (got.angle !== want.angle || got.distance !== want.distance ||
             got.strength !== want.strength || got.speed !== want.speed ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
               $display("reading mismatch at %0t", $time);
               $display("   expected angle %0d dist %0d strength %0d speed %0d last %0b",
                        want.angle, want.distance, want.strength, want.speed, want.last);
               $display("   actual   angle %0d dist %0d strength %0d speed %0d last %0b",
                        got.angle, got.distance, got.strength, got.speed, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_pos = lrpd_pkg::POS_SYNC;
         expected_readings.delete();
         mismatches       = 0;
         readings_checked = 0;
         packets_good     = 0;
         packets_dropped  = 0;
      end else begin
         // byte first, so a same-cycle reading would still find its prediction
         if (req_valid && req_ready) begin
            decode_byte(req_byte);
         end
         if (rsp_valid && rsp_ready) begin
            check_reading();
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

/* sim/tb.sv */
// Top of the range packet decoder bench: clock, reset, byte stimulus and reading
// back-pressure, verdict. Depends on lrpd_pkg, lrpd_req_if, lrpd_rsp_if, the
// decoder and lrpd_scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES  = 22;
   localparam int HOLD_CYCLES  = 80;       // long reading stall, fills the output bank
   localparam int DRAIN_CYCLES = 16;       // quiet time after the last reading
   localparam int CYCLE_LIMIT  = 200000;

   // what a generated frame looks like on the wire
   typedef enum int {
      FRAME_GOOD,       // valid checksum
      FRAME_BAD_SUM,    // low 15 checksum bits corrupted
      FRAME_SUM_MSB,    // correct checksum but bit 15 set, never matches
      FRAME_CUT         // stops short, next bytes land in its payload
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrpd_req_if req_ch ();
   lrpd_rsp_if rsp_ch ();

   int mismatches;
   int readings_pending;
   int readings_checked;
   int packets_good;
   int packets_dropped;

   int gap_pct    = 0;    // chance per cycle that the byte source idles
   int stall_pct  = 0;    // chance per cycle that the reading sink stalls
   int bytes_sent = 0;
   int cycle_count = 0;

   // long-stall request: stimulus bumps hold_kicks, the sink process serves it
   int hold_kicks = 0;
   int hold_done  = 0;
   int hold_left  = 0;

   lidar_range_packet_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lrpd_scoreboard i_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_byte         (req_ch.rx_byte),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_angle        (rsp_ch.angle_deg),
      .rsp_distance     (rsp_ch.distance_mm),
      .rsp_strength     (rsp_ch.signal_strength),
      .rsp_speed        (rsp_ch.speed_raw),
      .rsp_last         (rsp_ch.last_of_packet),
      .mismatches       (mismatches),
      .readings_pending (readings_pending),
      .readings_checked (readings_checked),
      .packets_good     (packets_good),
      .packets_dropped  (packets_dropped)
   );

   always #10 clock = ~clock;

   // hard stop if the handshakes ever hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings still due", cycle_count,
                  readings_pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // reading sink: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_kicks != hold_done) begin
         hold_done <= hold_kicks;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // payload word, biased toward the corners and toward sync bytes in the payload
   function automatic logic [lrpd_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return {lrpd_pkg::SYNC_BYTE, lrpd_pkg::SYNC_BYTE};
         default: return lrpd_pkg::WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [lrpd_pkg::BYTE_W-1:0] pick_index();
      case ($urandom_range(5))
         0: return lrpd_pkg::INDEX_LO;
         1: return lrpd_pkg::INDEX_HI;
         default: return lrpd_pkg::BYTE_W'($urandom_range(lrpd_pkg::INDEX_LO,
                                                          lrpd_pkg::INDEX_HI));
      endcase
   endfunction

   // index-slot byte that is neither a valid index nor a repeated sync
   function automatic logic [lrpd_pkg::BYTE_W-1:0] pick_bad_index();
      if ($urandom_range(1)) begin
         return lrpd_pkg::BYTE_W'($urandom_range(0, lrpd_pkg::INDEX_LO - 1));
      end
      return lrpd_pkg::BYTE_W'($urandom_range(lrpd_pkg::SYNC_BYTE + 1, 8'hFF));
   endfunction

   // Called and returns at a falling edge. valid stays high from one word to the
   // next unless a random gap is taken, so no double assignment in a time step.
   task automatic send_byte(input logic [lrpd_pkg::BYTE_W-1:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= lrpd_pkg::BYTE_W'($urandom);
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   // Packet: sync, optional repeated syncs, index, speed, four readings, checksum,
   // cut short for FRAME_CUT. fill < 0 gives random payload words, else all are fill.
   task automatic send_frame(input logic [lrpd_pkg::BYTE_W-1:0] index,
                             input frame_kind_type kind,
                             input int extra_syncs, input int fill);
      logic [lrpd_pkg::BYTE_W-1:0] fr [FRAME_BYTES];
      logic [31:0]                 acc;
      logic [lrpd_pkg::WORD_W-1:0] sum_word;
      int                          n;
      int                          len;
      fr[0] = lrpd_pkg::SYNC_BYTE;
      fr[1] = index;
      for (n = 2; n < 20; n += 2) begin
         {fr[n+1], fr[n]} = (fill < 0) ? pick_word() : lrpd_pkg::WORD_W'(fill);
      end
      acc = '0;
      for (n = 0; n < 20; n += 2) begin
         acc = (acc << 1) + {fr[n+1], fr[n]};
      end
      sum_word = lrpd_pkg::WORD_W'(((acc & 32'h7FFF) + (acc >> 15)) & 32'h7FFF);
      case (kind)
         FRAME_BAD_SUM: sum_word ^= lrpd_pkg::WORD_W'($urandom_range(1, 16'h7FFF));
         FRAME_SUM_MSB: sum_word |= 16'h8000;
         default: ;
      endcase
      {fr[21], fr[20]} = sum_word;
      len = (kind == FRAME_CUT) ? $urandom_range(2, FRAME_BYTES - 1) : FRAME_BYTES;
      send_byte(fr[0]);
      repeat (extra_syncs) begin
         send_byte(lrpd_pkg::SYNC_BYTE);
      end
      for (n = 1; n < len; n++) begin
         send_byte(fr[n]);
      end
   endtask

   // Mostly well-formed packets with random content; the rest are dropped
   // packets, bad index bytes, cut packets and line noise. Runs until both the
   // byte budget and the good-packet budget are met.
   task automatic run_traffic(input int byte_goal, input int packet_goal);
      int stop_bytes;
      int stop_packets;
      int pick;
      stop_bytes   = bytes_sent + byte_goal;
      stop_packets = packets_good + packet_goal;
      while (bytes_sent < stop_bytes || packets_good < stop_packets) begin
         pick = $urandom_range(99);
         if (pick < 62) begin
            send_frame(pick_index(), FRAME_GOOD,
                       ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0, -1);
         end else if (pick < 72) begin
            send_frame(pick_index(), FRAME_BAD_SUM, 0, -1);
         end else if (pick < 78) begin
            send_frame(pick_index(), FRAME_SUM_MSB, 0, -1);
         end else if (pick < 84) begin
            send_byte(lrpd_pkg::SYNC_BYTE);
            send_byte(pick_bad_index());
         end else if (pick < 90) begin
            send_frame(pick_index(), FRAME_CUT, 0, -1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(lrpd_pkg::BYTE_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      gap_pct   = 10;
      stall_pct = 66;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: index just outside the range on both sides
      send_byte(lrpd_pkg::SYNC_BYTE);
      send_byte(lrpd_pkg::BYTE_W'(lrpd_pkg::INDEX_LO - 1));
      send_byte(lrpd_pkg::SYNC_BYTE);
      send_byte(lrpd_pkg::BYTE_W'(lrpd_pkg::SYNC_BYTE + 1));
      // repeated sync before the index, top index, all-ones words
      send_frame(lrpd_pkg::INDEX_HI, FRAME_GOOD, 2, 32'hFFFF);
      // lowest index, all-zero words, then sync bytes throughout the payload
      send_frame(lrpd_pkg::INDEX_LO, FRAME_GOOD, 0, 0);
      send_frame(lrpd_pkg::INDEX_LO, FRAME_GOOD, 0,
                 int'({lrpd_pkg::SYNC_BYTE, lrpd_pkg::SYNC_BYTE}));
      // bad checksum, then a checksum word with its top bit set
      send_frame(pick_index(), FRAME_BAD_SUM, 0, -1);
      send_frame(pick_index(), FRAME_SUM_MSB, 0, -1);

      // phase 1: light source gaps, heavy sink stalls
      run_traffic(30, 1);

      // phase 2: the other way round
      gap_pct   = 66;
      stall_pct = 10;
      run_traffic(30, 1);

      // phase 3: full rate; first a long sink hold while two packets stream in
      // back to back, so the bank stays full and the last byte gets stalled
      gap_pct   = 0;
      stall_pct = 0;
      hold_kicks++;
      send_frame(pick_index(), FRAME_GOOD, 0, -1);
      send_frame(pick_index(), FRAME_GOOD, 0, -1);
      run_traffic(30, 1);

      req_ch.valid <= 1'b0;
      while (readings_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes: %0d packets decoded, %0d dropped on checksum",
               bytes_sent, packets_good, packets_dropped);
      $display("%0d readings compared, %0d mismatches", readings_checked, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
